// File: sv/kseq_pkg.sv
`default_nettype none
package kseq_pkg;

  // key codes as reported on the output channel
  typedef enum logic [3:0] {
    KEY_EOF       = 4'd0,
    KEY_CANCEL    = 4'd1,
    KEY_CTRL_D    = 4'd2,
    KEY_ENTER     = 4'd3,
    KEY_TAB       = 4'd4,
    KEY_BACKSPACE = 4'd5,
    KEY_DELETE    = 4'd6,
    KEY_INSERT    = 4'd7,
    KEY_LEFT      = 4'd8,
    KEY_RIGHT     = 4'd9,
    KEY_UP        = 4'd10,
    KEY_DOWN      = 4'd11,
    KEY_HOME      = 4'd12,
    KEY_END       = 4'd13,
    KEY_TEXT      = 4'd14,
    KEY_OTHER     = 4'd15
  } key_code_t;

  // decoder phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ESC  = 3'd1,
    PH_CSI  = 3'd2,
    PH_SS3  = 3'd3,
    PH_SKIP = 3'd4,
    PH_TEXT = 3'd5
  } phase_t;

  // byte codes
  localparam logic [7:0] BYTE_LF        = 8'h0A;
  localparam logic [7:0] BYTE_CR        = 8'h0D;
  localparam logic [7:0] BYTE_TAB       = 8'h09;
  localparam logic [7:0] BYTE_CTRL_C    = 8'h03;
  localparam logic [7:0] BYTE_CTRL_D    = 8'h04;
  localparam logic [7:0] BYTE_DEL       = 8'h7F;
  localparam logic [7:0] BYTE_BS        = 8'h08;
  localparam logic [7:0] BYTE_CTRL_A    = 8'h01;
  localparam logic [7:0] BYTE_CTRL_E    = 8'h05;
  localparam logic [7:0] BYTE_ESC       = 8'h1B;
  localparam logic [7:0] BYTE_SPACE     = 8'h20;
  localparam logic [7:0] BYTE_LBRACKET  = 8'h5B;
  localparam logic [7:0] BYTE_UPPER_O   = 8'h4F;
  localparam logic [7:0] BYTE_UPPER_A   = 8'h41;
  localparam logic [7:0] BYTE_UPPER_B   = 8'h42;
  localparam logic [7:0] BYTE_UPPER_C   = 8'h43;
  localparam logic [7:0] BYTE_UPPER_D   = 8'h44;
  localparam logic [7:0] BYTE_UPPER_F   = 8'h46;
  localparam logic [7:0] BYTE_UPPER_H   = 8'h48;
  localparam logic [7:0] BYTE_DIGIT_1   = 8'h31;
  localparam logic [7:0] BYTE_DIGIT_2   = 8'h32;
  localparam logic [7:0] BYTE_DIGIT_3   = 8'h33;
  localparam logic [7:0] BYTE_DIGIT_4   = 8'h34;
  localparam logic [7:0] BYTE_DIGIT_7   = 8'h37;
  localparam logic [7:0] BYTE_DIGIT_8   = 8'h38;

  // utf-8 lead byte masks and patterns
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;

  localparam logic [2:0] TEXT_MAX = 3'd4;

  // one decoded key event
  typedef struct packed {
    key_code_t   key_code;
    logic [31:0] text_bytes;
    logic [2:0]  text_length;
    logic        last_of_run;
  } result_t;

  // results caused by one byte, handed from decoder to queue
  typedef struct packed {
    result_t    first;
    result_t    second;
    logic [1:0] count;
  } decode_out_t;

endpackage
`default_nettype wire

// File: sv/kseq_in_if.sv
`default_nettype none
interface kseq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       stream_end;

  modport source (output valid, output byte_value, output stream_end, input ready);
  modport sink (input valid, input byte_value, input stream_end, output ready);
endinterface
`default_nettype wire

// File: sv/kseq_out_if.sv
`default_nettype none
interface kseq_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  key_code;
  logic [31:0] text_bytes;
  logic [2:0]  text_length;
  logic        last_of_run;

  modport source (output valid, output key_code, output text_bytes, output text_length,
                  output last_of_run, input ready);
  modport sink (input valid, input key_code, input text_bytes, input text_length,
                input last_of_run, output ready);
endinterface
`default_nettype wire

// File: sv/kseq_decode.sv
`default_nettype none
module kseq_decode (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire logic [7:0]           byte_value,
  input  wire logic                 stream_end,
  output kseq_pkg::decode_out_t     dec
);
  import kseq_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] gathered_text, gathered_text_next;
  logic [2:0]  gathered_count, gathered_count_next;
  logic [2:0]  expected_count, expected_count_next;

  logic [31:0] merged_text;
  logic [2:0]  merged_count;
  logic [2:0]  lead_len;
  key_code_t   final_code;

  function automatic result_t make_result(key_code_t code, logic [31:0] bytes,
                                          logic [2:0] len);
    result_t r;
    r.key_code    = code;
    r.text_bytes  = bytes;
    r.text_length = len;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // utf-8 length announced by a lead byte
  always_comb begin
    if (!byte_value[7]) begin
      lead_len = 3'd1;
    end else if ((byte_value & LEAD2_MASK) == LEAD2_PAT) begin
      lead_len = 3'd2;
    end else if ((byte_value & LEAD3_MASK) == LEAD3_PAT) begin
      lead_len = 3'd3;
    end else if ((byte_value & LEAD4_MASK) == LEAD4_PAT) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd1;
    end
  end

  // final byte of csi and ss3 sequences
  always_comb begin
    unique case (byte_value)
      BYTE_UPPER_C: final_code = KEY_RIGHT;
      BYTE_UPPER_D: final_code = KEY_LEFT;
      BYTE_UPPER_A: final_code = KEY_UP;
      BYTE_UPPER_B: final_code = KEY_DOWN;
      BYTE_UPPER_H: final_code = KEY_HOME;
      BYTE_UPPER_F: final_code = KEY_END;
      default:      final_code = KEY_OTHER;
    endcase
  end

  // continuation byte merged into the character being gathered
  always_comb begin
    merged_text = gathered_text;
    if (gathered_count < TEXT_MAX) begin
      merged_text = gathered_text
                  | ({24'd0, byte_value} << {gathered_count[1:0], 3'b000});
    end
    merged_count = gathered_count + 3'd1;
  end

  // next state and results
  always_comb begin
    phase_next          = phase;
    gathered_text_next  = gathered_text;
    gathered_count_next = gathered_count;
    expected_count_next = expected_count;
    dec.first  = make_result(KEY_EOF, 32'd0, 3'd0);
    dec.second = make_result(KEY_EOF, 32'd0, 3'd0);
    dec.count  = 2'd0;

    if (stream_end) begin
      // flush whatever is pending, then eof
      unique case (phase)
        PH_ESC, PH_CSI, PH_SS3: begin
          dec.first = make_result(KEY_OTHER, 32'd0, 3'd0);
          dec.count = 2'd2;
        end
        PH_TEXT: begin
          dec.first = make_result(KEY_TEXT, gathered_text, gathered_count);
          dec.count = 2'd2;
        end
        default: begin
          dec.first = make_result(KEY_EOF, 32'd0, 3'd0);
          dec.count = 2'd1;
        end
      endcase
      phase_next          = PH_IDLE;
      gathered_text_next  = 32'd0;
      gathered_count_next = 3'd0;
      expected_count_next = 3'd0;
    end else begin
      unique case (phase)
        PH_ESC: begin
          if (byte_value == BYTE_LBRACKET) begin
            phase_next = PH_CSI;
          end else if (byte_value == BYTE_UPPER_O) begin
            phase_next = PH_SS3;
          end else begin
            dec.first  = make_result(KEY_OTHER, 32'd0, 3'd0);
            dec.count  = 2'd1;
            phase_next = PH_IDLE;
          end
        end
        PH_CSI: begin
          dec.count  = 2'd1;
          phase_next = PH_SKIP;
          unique case (byte_value) inside
            BYTE_DIGIT_2:               dec.first = make_result(KEY_INSERT, 32'd0, 3'd0);
            BYTE_DIGIT_3:               dec.first = make_result(KEY_DELETE, 32'd0, 3'd0);
            BYTE_DIGIT_1, BYTE_DIGIT_7: dec.first = make_result(KEY_HOME, 32'd0, 3'd0);
            BYTE_DIGIT_4, BYTE_DIGIT_8: dec.first = make_result(KEY_END, 32'd0, 3'd0);
            default: begin
              dec.first  = make_result(final_code, 32'd0, 3'd0);
              phase_next = PH_IDLE;
            end
          endcase
        end
        PH_SS3: begin
          dec.first  = make_result(final_code, 32'd0, 3'd0);
          dec.count  = 2'd1;
          phase_next = PH_IDLE;
        end
        PH_SKIP: begin
          phase_next = PH_IDLE;
        end
        PH_TEXT: begin
          gathered_text_next  = merged_text;
          gathered_count_next = merged_count;
          if (merged_count >= expected_count || merged_count >= TEXT_MAX) begin
            dec.first           = make_result(KEY_TEXT, merged_text, merged_count);
            dec.count           = 2'd1;
            phase_next          = PH_IDLE;
            gathered_text_next  = 32'd0;
            gathered_count_next = 3'd0;
            expected_count_next = 3'd0;
          end
        end
        default: begin
          // idle, also the unused phase codes
          phase_next = PH_IDLE;
          dec.count  = 2'd1;
          unique case (byte_value) inside
            BYTE_LF, BYTE_CR: dec.first = make_result(KEY_ENTER, 32'd0, 3'd0);
            BYTE_TAB:         dec.first = make_result(KEY_TAB, 32'd0, 3'd0);
            BYTE_CTRL_C:      dec.first = make_result(KEY_CANCEL, 32'd0, 3'd0);
            BYTE_CTRL_D:      dec.first = make_result(KEY_CTRL_D, 32'd0, 3'd0);
            BYTE_DEL, BYTE_BS: dec.first = make_result(KEY_BACKSPACE, 32'd0, 3'd0);
            BYTE_CTRL_A:      dec.first = make_result(KEY_HOME, 32'd0, 3'd0);
            BYTE_CTRL_E:      dec.first = make_result(KEY_END, 32'd0, 3'd0);
            BYTE_ESC: begin
              dec.count  = 2'd0;
              phase_next = PH_ESC;
            end
            default: begin
              if (byte_value < BYTE_SPACE) begin
                dec.first = make_result(KEY_OTHER, 32'd0, 3'd0);
              end else if (lead_len == 3'd1) begin
                dec.first = make_result(KEY_TEXT, {24'd0, byte_value}, 3'd1);
              end else begin
                dec.count           = 2'd0;
                gathered_text_next  = {24'd0, byte_value};
                gathered_count_next = 3'd1;
                expected_count_next = lead_len;
                phase_next          = PH_TEXT;
              end
            end
          endcase
        end
      endcase
    end

    // mark the final result of this byte
    if (dec.count == 2'd1) begin
      dec.first.last_of_run = 1'b1;
    end else if (dec.count == 2'd2) begin
      dec.second.last_of_run = 1'b1;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      gathered_text  <= 32'd0;
      gathered_count <= 3'd0;
      expected_count <= 3'd0;
    end else if (fire) begin
      phase          <= phase_next;
      gathered_text  <= gathered_text_next;
      gathered_count <= gathered_count_next;
      expected_count <= expected_count_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/kseq_queue.sv
`default_nettype none
module kseq_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire kseq_pkg::decode_out_t dec,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output kseq_pkg::result_t         head
);
  import kseq_pkg::*;

  result_t    entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count, count_next;
  logic [1:0] push_n;
  logic       pop;

  assign push_n    = push ? dec.count : 2'd0;
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && out_ready;
  assign head      = entries[rd_ptr];
  // two free slots guarantee any byte's results fit
  assign room      = (count <= 3'd2);

  always_comb begin
    count_next = count + {1'b0, push_n} - {2'd0, pop};
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= dec.first;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr + 2'd1] <= dec.second;
    end
  end

endmodule
`default_nettype wire

// File: sv/terminal_key_sequence_decoder_core.sv
// Terminal key decoder: takes one raw terminal byte (or an end-of-stream marker) per
// transaction on raw and delivers decoded key events on keys. A byte is taken every
// cycle while the queue has room; it is held in an input register, decoded in a single
// pass, and its results are written into a four-entry result queue, from which keys
// are offered on keys. Most bytes give zero or one event; end of stream with a
// pending sequence gives two. The queue drains one event per cycle while keys is ready.
// Input is held off only while the queue has fewer than two free entries.
`default_nettype none
module terminal_key_sequence_decoder_core (
  input  wire logic clk,
  input  wire logic rst,
  kseq_in_if.sink   raw,
  kseq_out_if.source keys
);
  import kseq_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_end;
  logic        fire;
  logic        room;
  decode_out_t dec;
  result_t     head;

  assign fire      = in_valid && room;
  assign raw.ready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (raw.ready) begin
      in_valid <= raw.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (raw.valid && raw.ready) begin
      in_byte <= raw.byte_value;
      in_end  <= raw.stream_end;
    end
  end

  // single pass decode
  kseq_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .byte_value (in_byte),
    .stream_end (in_end),
    .dec        (dec)
  );

  // result queue
  kseq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .dec       (dec),
    .room      (room),
    .out_valid (keys.valid),
    .out_ready (keys.ready),
    .head      (head)
  );

  assign keys.key_code    = head.key_code;
  assign keys.text_bytes  = head.text_bytes;
  assign keys.text_length = head.text_length;
  assign keys.last_of_run = head.last_of_run;

endmodule
`default_nettype wire

// File: sv/kseq_checker.sv
`default_nettype none
module kseq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  key_code,
  input wire logic [31:0] text_bytes,
  input wire logic [2:0]  text_length,
  input wire logic        last_of_run
);
  import kseq_pkg::*;

  // a pending key stays offered until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("key dropped while stalled");

  // nothing to deliver right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("key offered after reset");

  // non-text keys carry no bytes
  a_non_text: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_code != KEY_TEXT |-> text_length == 3'd0 && text_bytes == 32'd0)
    else $error("non-text key with text");

  // text keys carry one to four bytes
  a_text_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_code == KEY_TEXT |-> text_length != 3'd0 && text_length <= 3'd4)
    else $error("bad text length");

  // eof always ends its run
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_code == KEY_EOF |-> last_of_run)
    else $error("eof not last of run");

endmodule

bind terminal_key_sequence_decoder_core kseq_checker u_kseq_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (keys.valid),
  .out_ready   (keys.ready),
  .key_code    (keys.key_code),
  .text_bytes  (keys.text_bytes),
  .text_length (keys.text_length),
  .last_of_run (keys.last_of_run)
);
`default_nettype wire

// File: tb/kseq_decode_checker.sv
`timescale 1ns / 100ps
module kseq_decode_checker (
  input  logic clk,
  input  logic rst,
  kseq_in_if   raw,
  kseq_out_if  keys,
  output int   fail_count,
  output int   outstanding
);
  import kseq_pkg::*;

  // decoder state as predicted from the raw byte stream
  phase_t      phase_q;
  logic [31:0] gathered_q;
  logic [2:0]  gathered_n;
  logic [2:0]  announced_n;

  result_t expected_keys [$];
  int      mismatches;

  assign fail_count  = mismatches;
  assign outstanding = expected_keys.size();

  function automatic result_t make_key(key_code_t k, logic [31:0] t, logic [2:0] len);
    result_t ev;
    ev.key_code    = k;
    ev.text_bytes  = t;
    ev.text_length = len;
    ev.last_of_run = 1'b0;
    return ev;
  endfunction

  // final byte shared by csi and ss3 forms
  function automatic key_code_t final_byte_key(logic [7:0] b);
    case (b)
      BYTE_UPPER_C: return KEY_RIGHT;
      BYTE_UPPER_D: return KEY_LEFT;
      BYTE_UPPER_A: return KEY_UP;
      BYTE_UPPER_B: return KEY_DOWN;
      BYTE_UPPER_H: return KEY_HOME;
      BYTE_UPPER_F: return KEY_END;
      default:      return KEY_OTHER;
    endcase
  endfunction

  task automatic clear_gather();
    phase_q     = PH_IDLE;
    gathered_q  = '0;
    gathered_n  = '0;
    announced_n = '0;
  endtask

  // advance the predicted decoder by one transaction, queue the key events it causes
  task automatic predict_keys(input logic [7:0] b, input logic fin);
    result_t ev [2];
    int      n;
    int      lead_n;
    n = 0;
    if (fin) begin
      // flush whatever is pending, then eof
      case (phase_q)
        PH_ESC, PH_CSI, PH_SS3: begin
          ev[n] = make_key(KEY_OTHER, '0, '0);
          n++;
        end
        PH_TEXT: begin
          ev[n] = make_key(KEY_TEXT, gathered_q, gathered_n);
          n++;
        end
        default: ;
      endcase
      ev[n] = make_key(KEY_EOF, '0, '0);
      n++;
      clear_gather();
    end else begin
      case (phase_q)
        PH_ESC: begin
          if (b == BYTE_LBRACKET) phase_q = PH_CSI;
          else if (b == BYTE_UPPER_O) phase_q = PH_SS3;
          else begin
            ev[0]   = make_key(KEY_OTHER, '0, '0);
            n       = 1;
            phase_q = PH_IDLE;
          end
        end
        PH_CSI: begin
          // digit keys are reported at once, their trailer byte is dropped
          phase_q = PH_SKIP;
          case (b)
            BYTE_DIGIT_2:               ev[0] = make_key(KEY_INSERT, '0, '0);
            BYTE_DIGIT_3:               ev[0] = make_key(KEY_DELETE, '0, '0);
            BYTE_DIGIT_1, BYTE_DIGIT_7: ev[0] = make_key(KEY_HOME, '0, '0);
            BYTE_DIGIT_4, BYTE_DIGIT_8: ev[0] = make_key(KEY_END, '0, '0);
            default: begin
              ev[0]   = make_key(final_byte_key(b), '0, '0);
              phase_q = PH_IDLE;
            end
          endcase
          n = 1;
        end
        PH_SS3: begin
          phase_q = PH_IDLE;
          ev[0]   = make_key(final_byte_key(b), '0, '0);
          n       = 1;
        end
        PH_SKIP: phase_q = PH_IDLE;
        PH_TEXT: begin
          // continuation bytes are taken as they come, unchecked
          if (gathered_n < TEXT_MAX) gathered_q = gathered_q | (32'(b) << (8 * gathered_n));
          gathered_n = gathered_n + 3'd1;
          if (gathered_n >= announced_n || gathered_n >= TEXT_MAX) begin
            ev[0] = make_key(KEY_TEXT, gathered_q, gathered_n);
            n     = 1;
            clear_gather();
          end
        end
        default: begin
          phase_q = PH_IDLE;
          n       = 1;
          lead_n  = 1;
          if (b[7]) begin
            if ((b & LEAD2_MASK) == LEAD2_PAT) lead_n = 2;
            else if ((b & LEAD3_MASK) == LEAD3_PAT) lead_n = 3;
            else if ((b & LEAD4_MASK) == LEAD4_PAT) lead_n = 4;
          end
          case (b)
            BYTE_LF, BYTE_CR:  ev[0] = make_key(KEY_ENTER, '0, '0);
            BYTE_TAB:          ev[0] = make_key(KEY_TAB, '0, '0);
            BYTE_CTRL_C:       ev[0] = make_key(KEY_CANCEL, '0, '0);
            BYTE_CTRL_D:       ev[0] = make_key(KEY_CTRL_D, '0, '0);
            BYTE_DEL, BYTE_BS: ev[0] = make_key(KEY_BACKSPACE, '0, '0);
            BYTE_CTRL_A:       ev[0] = make_key(KEY_HOME, '0, '0);
            BYTE_CTRL_E:       ev[0] = make_key(KEY_END, '0, '0);
            BYTE_ESC: begin
              phase_q = PH_ESC;
              n       = 0;
            end
            default: begin
              if (b < BYTE_SPACE) ev[0] = make_key(KEY_OTHER, '0, '0);
              else if (lead_n == 1) ev[0] = make_key(KEY_TEXT, 32'(b), 3'd1);
              else begin
                gathered_q  = 32'(b);
                gathered_n  = 3'd1;
                announced_n = 3'(lead_n);
                phase_q     = PH_TEXT;
                n           = 0;
              end
            end
          endcase
        end
      endcase
    end
    if (n > 0) ev[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_keys = {expected_keys, ev[i]};
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_gather();
      expected_keys.delete();
      mismatches = 0;
    end else begin
      if (raw.valid && raw.ready) predict_keys(raw.byte_value, raw.stream_end);
      if (keys.valid && keys.ready) begin
        if (expected_keys.size() == 0) begin
          $error("unexpected key event: key_code %0d text_bytes %h",
                 keys.key_code, keys.text_bytes);
          mismatches++;
        end else begin
          want = expected_keys.pop_front();
          if (keys.key_code !== want.key_code) begin
            $error("key_code: expected %0d, actual %0d", want.key_code, keys.key_code);
            mismatches++;
          end
          if (keys.text_bytes !== want.text_bytes) begin
            $error("text_bytes: expected %h, actual %h", want.text_bytes, keys.text_bytes);
            mismatches++;
          end
          if (keys.text_length !== want.text_length) begin
            $error("text_length: expected %0d, actual %0d", want.text_length,
                   keys.text_length);
            mismatches++;
          end
          if (keys.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                   keys.last_of_run);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

// File: tb/terminal_key_sequence_decoder_core_tb.sv
`timescale 1ns / 100ps
module terminal_key_sequence_decoder_core_tb;
  import kseq_pkg::*;

  localparam int         RANDOM_ITEMS = 500;
  localparam int         HOLD_CYCLES  = 64;
  localparam int         DRAIN_CYCLES = 20;
  localparam logic [7:0] BYTE_TILDE   = 8'h7E;

  // directed opening: bit 8 marks end of stream
  localparam logic [8:0] OPENING [27] = '{
    {1'b0, BYTE_LF}, {1'b0, BYTE_TAB}, {1'b0, BYTE_CTRL_C}, {1'b0, BYTE_CTRL_D},
    {1'b0, BYTE_DEL}, {1'b0, BYTE_CTRL_A}, {1'b0, BYTE_CTRL_E}, 9'h000, 9'h0FF,
    // csi insert, then end of stream where the trailer belongs
    {1'b0, BYTE_ESC}, {1'b0, BYTE_LBRACKET}, {1'b0, BYTE_DIGIT_2}, 9'h1FF,
    // ss3 cut by end of stream
    {1'b0, BYTE_ESC}, {1'b0, BYTE_UPPER_O}, 9'h100,
    // esc with an unknown follower
    {1'b0, BYTE_ESC}, 9'h05A,
    // csi with an unknown final byte
    {1'b0, BYTE_ESC}, {1'b0, BYTE_LBRACKET}, 9'h07A,
    // truncated four-byte character
    9'h0F0, 9'h09F, 9'h155,
    // lone esc at end, then end while idle
    {1'b0, BYTE_ESC}, 9'h100, 9'h100
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   outstanding;
  int   sent_n = 0;
  logic src_gaps = 1'b1;
  logic sink_gaps = 1'b1;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;

  kseq_in_if  raw_ch ();
  kseq_out_if keys_ch ();

  terminal_key_sequence_decoder_core dut (
    .clk  (clk),
    .rst  (rst),
    .raw  (raw_ch),
    .keys (keys_ch)
  );

  kseq_decode_checker key_checker (
    .clk         (clk),
    .rst         (rst),
    .raw         (raw_ch),
    .keys        (keys_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // overall time limit
  initial begin
    #2_000_000;
    $display("FAIL terminal_key_sequence_decoder_core");
    $finish;
  end

  function automatic logic [8:0] data_item(logic [7:0] b);
    return {1'b0, b};
  endfunction

  // offer one raw transaction, with random idle cycles ahead of it
  task automatic send_item(input logic [7:0] b, input logic fin);
    if (src_gaps) begin
      while ($urandom_range(0, 99) < 26) begin
        raw_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    raw_ch.valid      <= 1'b1;
    raw_ch.byte_value <= b;
    raw_ch.stream_end <= fin;
    @(posedge clk);
    while (!raw_ch.ready) @(posedge clk);
    sent_n++;
  endtask

  // one random key sequence, mostly well formed, sometimes cut by end of stream
  task automatic send_token();
    logic [8:0] seq [$];
    logic [7:0] ctrl_set [9] = '{BYTE_LF, BYTE_CR, BYTE_TAB, BYTE_CTRL_C, BYTE_CTRL_D,
                                 BYTE_DEL, BYTE_BS, BYTE_CTRL_A, BYTE_CTRL_E};
    logic [7:0] finals [6] = '{BYTE_UPPER_A, BYTE_UPPER_B, BYTE_UPPER_C, BYTE_UPPER_D,
                               BYTE_UPPER_H, BYTE_UPPER_F};
    logic [7:0] digits [6] = '{BYTE_DIGIT_1, BYTE_DIGIT_2, BYTE_DIGIT_3, BYTE_DIGIT_4,
                               BYTE_DIGIT_7, BYTE_DIGIT_8};
    int kind;
    int len;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      seq = {seq, data_item(ctrl_set[$urandom_range(0, 8)])};
    end else if (kind < 20) begin
      seq = {seq, data_item(8'($urandom_range(0, 31)))};
    end else if (kind < 36) begin
      seq = {seq, data_item(8'($urandom_range(32, 127)))};
    end else if (kind < 52) begin
      // utf-8 character, continuation bytes now and then malformed
      len = $urandom_range(2, 4);
      case (len)
        2:       seq = {seq, data_item(LEAD2_PAT | 8'($urandom_range(0, 31)))};
        3:       seq = {seq, data_item(LEAD3_PAT | 8'($urandom_range(0, 15)))};
        default: seq = {seq, data_item(LEAD4_PAT | 8'($urandom_range(0, 7)))};
      endcase
      repeat (len - 1) begin
        if ($urandom_range(0, 7) == 0) seq = {seq, data_item(8'($urandom_range(0, 255)))};
        else seq = {seq, data_item(8'h80 | 8'($urandom_range(0, 63)))};
      end
    end else if (kind < 72) begin
      seq = {seq, data_item(BYTE_ESC)};
      seq = {seq, data_item(BYTE_LBRACKET)};
      case ($urandom_range(0, 3))
        0, 1: seq = {seq, data_item(finals[$urandom_range(0, 5)])};
        2: begin
          seq = {seq, data_item(digits[$urandom_range(0, 5)])};
          if ($urandom_range(0, 3) != 0) seq = {seq, data_item(BYTE_TILDE)};
          else seq = {seq, data_item(8'($urandom_range(0, 255)))};
        end
        default: seq = {seq, data_item(8'($urandom_range(0, 255)))};
      endcase
    end else if (kind < 82) begin
      seq = {seq, data_item(BYTE_ESC)};
      seq = {seq, data_item(BYTE_UPPER_O)};
      if ($urandom_range(0, 3) != 0) seq = {seq, data_item(finals[$urandom_range(0, 5)])};
      else seq = {seq, data_item(8'($urandom_range(0, 255)))};
    end else if (kind < 88) begin
      seq = {seq, data_item(BYTE_ESC)};
      seq = {seq, data_item(8'($urandom_range(0, 255)))};
    end else if (kind < 96) begin
      seq = {seq, data_item(8'($urandom_range(0, 255)))};
    end else begin
      seq = {seq, {1'b1, 8'($urandom_range(0, 255))}};
    end
    // cut a sequence short with end of stream
    if (seq.size() > 1 && $urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, seq.size() - 1);
      while (seq.size() > len) void'(seq.pop_back());
      seq = {seq, {1'b1, 8'($urandom_range(0, 255))}};
    end
    foreach (seq[i]) send_item(seq[i][7:0], seq[i][8]);
  endtask

  // key receiver: random stalls, one long hold-off on request
  initial begin
    keys_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          keys_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
      keys_ch.ready <= sink_gaps ? ($urandom_range(0, 99) >= 26) : 1'b1;
    end
  end

  // raw byte stimulus and verdict
  initial begin
    raw_ch.valid      <= 1'b0;
    raw_ch.byte_value <= '0;
    raw_ch.stream_end <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (OPENING[i]) send_item(OPENING[i][7:0], OPENING[i][8]);
    while (sent_n < RANDOM_ITEMS + $size(OPENING)) begin
      src_gaps  = !(sent_n >= 150 && sent_n < 300);
      sink_gaps = !(sent_n >= 330 && sent_n < 430);
      if (sent_n >= 180 && !hold_done) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      send_token();
    end
    raw_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS terminal_key_sequence_decoder_core");
    end else begin
      $display("FAIL terminal_key_sequence_decoder_core");
    end
    $finish;
  end

endmodule
